/* rtl/pkd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkd_pkg
// Shared types and constants of the plateau-aware peak detector.
// ----------------------------------------------------------------------------
package pkd_pkg;

   // frame and sample sizing
   localparam int MAX_FRAME   = 4096;
   localparam int SAMPLE_BITS = 16;

   // port widths fixed by the interface
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 12;

   // internal index width follows the frame limit
   localparam int INDEX_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(MAX_FRAME - 1);

   // only the low SAMPLE_BITS bits of a sample take part in compares
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   // three-way slope tracking
   typedef enum logic [1:0] {
      TREND_FALLING = 2'd0,
      TREND_RISING  = 2'd1,
      TREND_LEVEL   = 2'd2
   } trend_type;

   // peak report from the tracker to the output stage
   typedef struct packed {
      logic             hit;
      logic             wide;
      logic [OUT_W-1:0] start_idx;
      logic [OUT_W-1:0] end_idx;
   } peak_type;

endpackage
`default_nettype wire

/* rtl/pkd_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkd_track
// Slope tracker: holds the previous sample, trend, plateau start and index,
// and decides combinationally whether the current word ends a peak.
// ----------------------------------------------------------------------------
module pkd_track
   import pkd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                frame_start,
   input  wire logic [SAMPLE_W-1:0] threshold,
   output peak_type                 peak
);

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                have_prev_ff, have_prev_in;
   trend_type           trend_ff, trend_in;
   logic [INDEX_W-1:0]  plat_ff, plat_in;
   logic [INDEX_W-1:0]  index_ff, index_in;

   logic [SAMPLE_W-1:0] cur;
   logic [SAMPLE_W-1:0] thr;
   logic                restart;
   logic                fall;
   logic                level;
   logic                above;

   // masked operands
   assign cur     = sample & SAMPLE_MASK;
   assign thr     = threshold & SAMPLE_MASK;
   assign restart = frame_start || !have_prev_ff;
   assign fall    = cur < prev_ff;
   assign level   = cur == prev_ff;
   assign above   = prev_ff > thr;

   // peak decision and next state
   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      trend_in     = trend_ff;
      plat_in      = plat_ff;
      index_in     = index_ff;

      peak.hit       = 1'b0;
      peak.wide      = (trend_ff == TREND_LEVEL);
      peak.start_idx = (trend_ff == TREND_LEVEL) ? OUT_W'(plat_ff) : OUT_W'(index_ff);
      peak.end_idx   = OUT_W'(index_ff);

      if (restart) begin
         have_prev_in = 1'b1;
         prev_in      = cur;
         trend_in     = TREND_FALLING;
         plat_in      = '0;
         index_in     = '0;
      end else begin
         if (fall) begin
            peak.hit = above &&
                       ((trend_ff == TREND_RISING) || (trend_ff == TREND_LEVEL));
            trend_in = TREND_FALLING;
         end else if (level) begin
            if (trend_ff == TREND_RISING) begin
               plat_in  = index_ff;
               trend_in = TREND_LEVEL;
            end
         end else begin
            trend_in = TREND_RISING;
         end
         prev_in = cur;
         // index saturates at the last frame position
         if (index_ff != INDEX_LAST) begin
            index_in = index_ff + INDEX_W'(1);
         end
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         trend_ff     <= TREND_FALLING;
         plat_ff      <= '0;
         index_ff     <= '0;
      end else if (step) begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         trend_ff     <= trend_in;
         plat_ff      <= plat_in;
         index_ff     <= index_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/plateau_aware_peak_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plateau_aware_peak_detector
// Streams amplitude samples and reports sharp and plateau peaks above a
// programmable threshold.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_sample, req_frame_start
//   rsp      out        rsp_valid/rsp_ready   rsp_peak_is_wide, rsp_peak_start,
//                                             rsp_peak_end
//   csr      in         csr_valid/csr_ready   csr_data (threshold)
//
// One word per cycle sustained while the result is not stalled; a word enters
// the input register, then the tracker compares it with the stored previous
// sample and loads any peak into the result register.
// A stalled result holds the pipeline; an empty input register can still
// take one word while the result register waits. Synchronous reset clears the
// tracker, the valid flags and the threshold (to zero); no ready during reset.
// ----------------------------------------------------------------------------
module plateau_aware_peak_detector
   import pkd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input words
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic                req_frame_start,
   // peak reports
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_peak_is_wide,
   output      logic [OUT_W-1:0]    rsp_peak_start,
   output      logic [OUT_W-1:0]    rsp_peak_end,
   // threshold write
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [SAMPLE_W-1:0] csr_data
);

   logic                in_vld_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_start_ff;
   logic [SAMPLE_W-1:0] thr_ff;
   logic                out_vld_ff;
   logic                out_wide_ff;
   logic [OUT_W-1:0]    out_start_ff;
   logic [OUT_W-1:0]    out_end_ff;

   logic                move;
   peak_type            peak;

   // pipeline advance when the result register is free or being drained
   assign move      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !reset && (!in_vld_ff || move);
   assign csr_ready = !reset;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
         in_start_ff  <= req_frame_start;
      end
   end

   // slope tracker
   pkd_track u_track (
      .clock       (clock),
      .reset       (reset),
      .step        (move),
      .sample      (in_sample_ff),
      .frame_start (in_start_ff),
      .threshold   (thr_ff),
      .peak        (peak)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move) begin
         out_vld_ff <= peak.hit;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move && peak.hit) begin
         out_wide_ff  <= peak.wide;
         out_start_ff <= peak.start_idx;
         out_end_ff   <= peak.end_idx;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_peak_is_wide = out_wide_ff;
   assign rsp_peak_start   = out_start_ff;
   assign rsp_peak_end     = out_end_ff;

endmodule
`default_nettype wire

/* sim/plateau_aware_peak_detector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plateau_aware_peak_detector_test
// Self-checking bench for the plateau-aware peak detector. A clocked driver
// feeds sample words from a queue, and a clocked monitor checks every peak
// report against a local tracker of rising, level and falling runs. The
// threshold is rewritten between phases while the block is idle. The phases
// run directed corner words, short random frames near the threshold, and one
// longer frame, under several stall patterns.
// ----------------------------------------------------------------------------
module plateau_aware_peak_detector_test
   import pkd_pkg::*;
();

   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_FRAME   = 60;

   // one queued input word
   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_start;
      logic                hold;
   } pending_word_type;

   // one predicted peak report
   typedef struct {
      logic             wide;
      logic [OUT_W-1:0] first;
      logic [OUT_W-1:0] last;
   } peak_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_peak_is_wide;
   logic [OUT_W-1:0]    rsp_peak_start;
   logic [OUT_W-1:0]    rsp_peak_end;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SAMPLE_W-1:0] csr_data = '0;

   pending_word_type pending_words[$];
   peak_report_type  expected_peaks[$];
   int               mismatches  = 0;
   int               cycle_count = 0;
   int               send_idle   = 0;
   int               recv_idle   = 0;

   // tracker state, mirrors the block
   logic [SAMPLE_W-1:0] active_threshold = '0;
   logic [SAMPLE_W-1:0] last_amp = '0;
   logic                seen_word = 1'b0;
   trend_type           slope = TREND_FALLING;
   int                  plateau_first = 0;
   int                  amp_index = 0;

   plateau_aware_peak_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_is_wide (rsp_peak_is_wide),
      .rsp_peak_start   (rsp_peak_start),
      .rsp_peak_end     (rsp_peak_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // track the slope of one accepted word and queue any peak it closes
   task automatic predict_word(input logic [SAMPLE_W-1:0] word_sample,
                               input logic word_start);
      logic [SAMPLE_W-1:0] cur;
      logic [SAMPLE_W-1:0] thr;
      peak_report_type     found;
      cur = word_sample & SAMPLE_MASK;
      thr = active_threshold & SAMPLE_MASK;
      if (word_start || !seen_word) begin
         // new frame, or first word ever: restart at index zero
         seen_word     = 1'b1;
         last_amp      = cur;
         slope         = TREND_FALLING;
         plateau_first = 0;
         amp_index     = 0;
      end else begin
         if (cur < last_amp) begin
            if (last_amp > thr && slope != TREND_FALLING) begin
               found.wide  = (slope == TREND_LEVEL);
               found.first = OUT_W'((slope == TREND_LEVEL) ? plateau_first : amp_index);
               found.last  = OUT_W'(amp_index);
               expected_peaks.insert(expected_peaks.size(), found);
            end
            slope = TREND_FALLING;
         end else if (cur == last_amp) begin
            // a level step only opens a plateau after a rise
            if (slope == TREND_RISING) begin
               plateau_first = amp_index;
               slope         = TREND_LEVEL;
            end
         end else begin
            slope = TREND_RISING;
         end
         last_amp = cur;
         // index saturates at the frame limit
         if (amp_index + 1 < MAX_FRAME) amp_index++;
      end
   endtask

   // driver: predict accepted words, then offer the next queued word
   always @(posedge clock) begin : drive_words
      pending_word_type next_word;
      if (!reset && req_valid && req_ready) predict_word(req_sample, req_frame_start);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() > 0 &&
             !(pending_words[0].hold && expected_peaks.size() > 0) &&
             $urandom_range(99) >= send_idle) begin
            next_word = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_sample      <= next_word.sample;
            req_frame_start <= next_word.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted report with the oldest prediction
   always @(posedge clock) begin : check_peaks
      peak_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_peaks.size() == 0) begin
            report_mismatch("unexpected peak, start", int'(rsp_peak_start), 0);
         end else begin
            want = expected_peaks.pop_front();
            if (rsp_peak_is_wide !== want.wide)
               report_mismatch("peak_is_wide", int'(rsp_peak_is_wide), int'(want.wide));
            if (rsp_peak_start !== want.first)
               report_mismatch("peak_start", int'(rsp_peak_start), int'(want.first));
            if (rsp_peak_end !== want.last)
               report_mismatch("peak_end", int'(rsp_peak_end), int'(want.last));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic int clamp_amp(input int v);
      return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
   endfunction

   task automatic add_word(input int amp, input logic start, input logic hold = 1'b0);
      pending_word_type w;
      w.sample      = SAMPLE_W'(amp);
      w.frame_start = start;
      w.hold        = hold;
      pending_words.insert(pending_words.size(), w);
   endtask

   // next amplitude of a random walk: plateaus, rises, falls and noise
   function automatic int next_amp(input int prev);
      case ($urandom_range(11))
         0, 1, 2: return prev;
         3, 4, 5: return clamp_amp(prev + int'($urandom_range(1, 300)));
         6, 7, 8: return clamp_amp(prev - int'($urandom_range(1, 300)));
         9:       return int'($urandom_range(65535));
         10:      return clamp_amp(int'(active_threshold) + int'($urandom_range(2)) - 1);
         default: return ($urandom_range(1) == 1) ? 65535 : 0;
      endcase
   endfunction

   // short random frames starting near the threshold
   task automatic add_random_frames(input int count, input int hold_at = -1);
      int added;
      int len;
      int amp;
      added = 0;
      while (added < count) begin
         len = ($urandom_range(9) == 0) ? int'($urandom_range(1, 2))
                                        : int'($urandom_range(3, 30));
         amp = clamp_amp(int'(active_threshold) + int'($urandom_range(1000)) - 500);
         for (int i = 0; i < len; i++) begin
            if (i > 0) amp = next_amp(amp);
            add_word(amp, i == 0, added == hold_at);
            added++;
         end
      end
   endtask

   task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_threshold = value;
   endtask

   // wait until every word is in and every report is out, then drain
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_peaks.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : run_phases
      int amp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle = 8;
      recv_idle = 51;

      // directed corner words at threshold zero
      write_threshold(16'h0000);
      // word before any frame start acts as a frame start, then sharp peak
      add_word(100, 1'b0);
      add_word(200, 1'b0);
      add_word(50, 1'b0);
      // level step while falling keeps falling, no peak
      add_word(16'hFFFF, 1'b1);
      add_word(16'hFFFF, 1'b0);
      add_word(0, 1'b0);
      // wide plateau at full scale
      add_word(0, 1'b1);
      add_word(16'hFFFF, 1'b0);
      add_word(16'hFFFF, 1'b0);
      add_word(16'hFFFF, 1'b0);
      add_word(16'hFFFE, 1'b0);
      // single-sample frames report nothing
      add_word(5, 1'b1);
      add_word(7, 1'b1);
      // frame start in the middle of a rise drops the pending peak
      add_word(10, 1'b1);
      add_word(20, 1'b0);
      add_word(5, 1'b1);
      // level then rise again gives a sharp peak
      add_word(1, 1'b1);
      add_word(2, 1'b0);
      add_word(2, 1'b0);
      add_word(3, 1'b0);
      add_word(1, 1'b0);
      // smallest peak above threshold zero
      add_word(0, 1'b1);
      add_word(1, 1'b0);
      add_word(0, 1'b0);
      wait_idle();

      // full-scale threshold: no peak can pass
      write_threshold(16'hFFFF);
      add_random_frames(60);
      wait_idle();

      // mid threshold, with one pause until all reports are back
      write_threshold(SAMPLE_W'($urandom_range(16'h2000, 16'hC000)));
      add_random_frames(450, 225);
      wait_idle();

      // swap the stall pattern
      send_idle = 51;
      recv_idle = 8;
      write_threshold(SAMPLE_W'($urandom_range(65535)));
      add_random_frames(420);
      wait_idle();

      // no stalls: one longer frame, then short frames
      send_idle = 0;
      recv_idle = 0;
      write_threshold(SAMPLE_W'($urandom_range(16'h7000, 16'h8000)));
      amp = int'(active_threshold);
      add_word(amp, 1'b1);
      for (int i = 1; i < LONG_FRAME; i++) begin
         amp = next_amp(amp);
         add_word(amp, 1'b0);
      end
      add_random_frames(36);
      wait_idle();

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/pkd_pkg.sv
rtl/pkd_track.sv
rtl/plateau_aware_peak_detector.sv
sim/plateau_aware_peak_detector_test.sv
